/* rtl/core/masked_multi_pattern_scanner_assert.svh */
// Assertion macros shared by the masked multi-pattern scanner RTL.
`ifndef MASKED_MULTI_PATTERN_SCANNER_ASSERT_SVH
`define MASKED_MULTI_PATTERN_SCANNER_ASSERT_SVH
`ifndef SYNTHESIS
`define MMPS_ASSERT_HOLD(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("scanner assertion failed");
`define MMPS_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("scanner assertion failed");
`else
`define MMPS_ASSERT_HOLD(label, cond, prop)
`define MMPS_ASSERT_NEXT(label, cond, prop)
`endif
`endif

/* rtl/core/mmps_pkg.sv */
// Package with the constants and types of the masked multi-pattern scanner.
`timescale 1ns / 1ps
package mmps_pkg;

    localparam int NUM_SIGS  = 8;
    localparam int MAX_LEN   = 32;
    localparam int SIG_W     = $clog2(NUM_SIGS);
    localparam int POS_W     = $clog2(MAX_LEN);
    localparam int LEN_W     = 6;
    localparam int OFS_W     = 16;
    localparam int ADDR_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int MEM_AW    = SIG_W + POS_W;
    localparam int MEM_DEPTH = NUM_SIGS * MAX_LEN;

    typedef enum logic [1:0] {
        KIND_PAT   = 2'd0,
        KIND_LEN   = 2'd1,
        KIND_SCAN  = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

    typedef struct packed {
        logic              wild;
        logic [BYTE_W-1:0] value;
    } t_pat_entry;

    localparam t_pat_entry WILD_ENTRY = '{wild: 1'b1, value: '0};

    typedef struct packed {
        logic             en;
        logic [SIG_W-1:0] sig;
        t_pat_entry       entry;
    } t_cell_wr;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    typedef struct packed {
        logic                load;
        logic [NUM_SIGS-1:0] mask;
        logic                status;
        logic                all_found;
        logic [ADDR_W-1:0]   base_cnt;
    } t_res_load;

endpackage

/* rtl/core/mmps_in_if.sv */
// Input channel interface of the scanner: handshake and input item fields.
`timescale 1ns / 1ps
interface mmps_in_if import mmps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [SIG_W-1:0]  sig_index;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] pattern_byte;
    logic              is_wildcard;
    logic [LEN_W-1:0]  sig_length;
    logic [OFS_W-1:0]  addr_offset;
    logic [BYTE_W-1:0] mem_byte;
    logic              last;

    modport source (
        output valid, kind, sig_index, position, pattern_byte, is_wildcard,
               sig_length, addr_offset, mem_byte, last,
        input  ready
    );
    modport sink (
        input  valid, kind, sig_index, position, pattern_byte, is_wildcard,
               sig_length, addr_offset, mem_byte, last,
        output ready
    );
endinterface

/* rtl/core/mmps_out_if.sv */
// Result channel interface of the scanner: handshake and result item fields.
`timescale 1ns / 1ps
interface mmps_out_if import mmps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SIG_W-1:0]  found_index;
    logic [ADDR_W-1:0] found_address;
    logic              is_status;
    logic              all_found;
    logic              last_of_run;

    modport source (
        output valid, found_index, found_address, is_status, all_found, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, found_index, found_address, is_status, all_found, last_of_run,
        output ready
    );
endinterface

/* rtl/core/masked_multi_pattern_scanner.sv */
// Top level of the masked multi-pattern scanner: stores, window cell chain and control.
`timescale 1ns / 1ps
`include "masked_multi_pattern_scanner_assert.svh"
// Usage. Items arrive on i_in with a valid/ready handshake; result items leave on
// o_out with the same handshake. An item loads a pattern byte, loads a length and
// offset, scans one region byte or clears the scan. The user must write base address
// and signature count on the i_cfg port while the block is idle; it does not enforce this.
// A pattern byte, a clear, or a scan byte that is not the last and finds nothing does
// not hold up the input. Other scan bytes hold it while the result sequencer hands
// out one result item a cycle as the receiver takes them; the first passes the mask
// register before the output register. A length load rebuilds the aligned pattern
// copies in the cell chain from the pattern memory, one position a cycle, single port.
// The window is a chain of 32 cells, each holding one history byte and, for every
// signature, the pattern entry that lines up with it; all cells compare in parallel.
// Synchronous reset clears lengths, offsets and the scan state and sets every cell
// entry to wildcard at once; the pattern memory itself is not cleared. When the receiver
// stalls, the output register holds its item and the block accepts a further item only
// once every pending result item of the earlier one has moved into the output register.
module masked_multi_pattern_scanner import mmps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    mmps_in_if.sink              i_in,
    mmps_out_if.source           o_out
);

    logic [ADDR_W-1:0]   r_base;
    logic [CNT_W-1:0]    r_sig_count;
    logic [LEN_W-1:0]    r_len [NUM_SIGS];
    logic [OFS_W-1:0]    r_ofs [NUM_SIGS];
    logic [NUM_SIGS-1:0] r_found;
    logic [ADDR_W-1:0]   r_count;
    logic                r_complete;
    logic                r_sweep_busy;
    logic [LEN_W-1:0]    r_sweep_cnt;
    logic [SIG_W-1:0]    r_sweep_sig;
    t_pat_entry          r_rd_entry;
    t_pat_entry          r_pat_mem [MEM_DEPTH];

    logic [NUM_SIGS-1:0] n_found;
    logic                n_complete;
    logic [ADDR_W-1:0]   n_count;

    t_kind               in_kind;
    logic                in_acc;
    logic                res_busy;
    logic                shift_en;
    logic                scan_clear;
    logic [LEN_W-1:0]    len_sel;
    logic [LEN_W-1:0]    len_sat;
    logic [LEN_W-1:0]    pat_q_full;
    logic                pos_in_len;
    logic [LEN_W-1:0]    sw_len;
    logic [LEN_W-1:0]    rd_pos_full;
    logic [LEN_W-1:0]    sw_wr_full;
    logic                wr_inrange;
    logic                wr_en;
    logic [POS_W-1:0]    wr_q;
    t_cell_wr            wr_base;
    t_cell_wr            cell_wr [MAX_LEN];
    t_cell_ctl           cell_ctl;
    logic [BYTE_W-1:0]   cell_byte [MAX_LEN];
    logic [NUM_SIGS-1:0] cell_hit [MAX_LEN];
    logic [NUM_SIGS-1:0] match;
    logic [NUM_SIGS-1:0] cnt_mask;
    logic [NUM_SIGS-1:0] len_ok;
    logic [NUM_SIGS-1:0] new_found;
    logic                all_found;
    t_res_load           res_load;

    assign in_kind    = t_kind'(i_in.kind);
    assign i_in.ready = !r_sweep_busy && !res_busy;
    assign in_acc     = i_in.valid && i_in.ready;

    assign len_sel    = r_len[i_in.sig_index];
    assign len_sat    = (i_in.sig_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : i_in.sig_length;
    assign pat_q_full = len_sel - LEN_W'(1) - LEN_W'(i_in.position);
    assign pos_in_len = LEN_W'(i_in.position) < len_sel;

    assign sw_len      = r_len[r_sweep_sig];
    assign rd_pos_full = sw_len - LEN_W'(1) - r_sweep_cnt;
    assign sw_wr_full  = r_sweep_cnt - LEN_W'(1);
    assign wr_inrange  = sw_wr_full < sw_len;

    always_ff @(posedge i_clk) begin
        if (in_acc && (in_kind == KIND_PAT)) begin
            r_pat_mem[{i_in.sig_index, i_in.position}] <= '{wild: i_in.is_wildcard,
                                                          value: i_in.pattern_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_entry <= r_pat_mem[{r_sweep_sig, rd_pos_full[POS_W-1:0]}];
    end

    always_comb begin
        if (r_sweep_busy) begin
            wr_en         = (r_sweep_cnt != '0);
            wr_q          = sw_wr_full[POS_W-1:0];
            wr_base.sig   = r_sweep_sig;
            wr_base.entry = wr_inrange ? r_rd_entry : WILD_ENTRY;
        end else begin
            wr_en         = in_acc && (in_kind == KIND_PAT) && pos_in_len;
            wr_q          = pat_q_full[POS_W-1:0];
            wr_base.sig   = i_in.sig_index;
            wr_base.entry = '{wild: i_in.is_wildcard, value: i_in.pattern_byte};
        end
        wr_base.en = wr_en;
    end

    assign n_count    = (&r_count) ? r_count : r_count + ADDR_W'(1);
    assign shift_en   = in_acc && (in_kind == KIND_SCAN) && !r_complete;
    assign scan_clear = in_acc && ((in_kind == KIND_CLEAR) ||
                                   ((in_kind == KIND_SCAN) && i_in.last));

    assign cell_ctl.shift = shift_en;
    assign cell_ctl.clear = scan_clear;

    for (genvar q = 0; q < MAX_LEN; q++) begin : g_cell
        always_comb begin
            cell_wr[q]    = wr_base;
            cell_wr[q].en = wr_en && (wr_q == POS_W'(q));
        end

        if (q == 0) begin : g_head
            mmps_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (cell_ctl),
                .i_wr    (cell_wr[q]),
                .i_byte  (i_in.mem_byte),
                .o_byte  (cell_byte[q]),
                .o_hit   (cell_hit[q])
            );
        end else begin : g_body
            mmps_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (cell_ctl),
                .i_wr    (cell_wr[q]),
                .i_byte  (cell_byte[q-1]),
                .o_byte  (cell_byte[q]),
                .o_hit   (cell_hit[q])
            );
        end
    end

    always_comb begin
        match = '1;
        for (int q = 0; q < MAX_LEN; q++) begin
            match = match & cell_hit[q];
        end
        for (int s = 0; s < NUM_SIGS; s++) begin
            cnt_mask[s] = CNT_W'(s) < r_sig_count;
            len_ok[s]   = ADDR_W'(r_len[s]) <= n_count;
        end
    end

    assign new_found  = shift_en ? (cnt_mask & ~r_found & match & len_ok) : '0;
    assign n_found    = r_found | new_found;
    assign all_found  = ((n_found & cnt_mask) == cnt_mask);
    assign n_complete = r_complete || (shift_en && all_found);

    assign res_load.load      = in_acc && (in_kind == KIND_SCAN) &&
                                ((new_found != '0) || i_in.last);
    assign res_load.mask      = new_found;
    assign res_load.status    = i_in.last;
    assign res_load.all_found = n_complete;
    assign res_load.base_cnt  = r_base + n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_sig_count  <= CNT_W'(1);
            r_found      <= '0;
            r_count      <= '0;
            r_complete   <= 1'b0;
            r_sweep_busy <= 1'b0;
            r_sweep_cnt  <= '0;
            r_sweep_sig  <= '0;
            for (int s = 0; s < NUM_SIGS; s++) begin
                r_len[s] <= '0;
                r_ofs[s] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE:  r_base      <= i_cfg_data;
                    CFG_COUNT: r_sig_count <= i_cfg_data[CNT_W-1:0];
                    default:   ;
                endcase
            end

            if (r_sweep_busy) begin
                if (r_sweep_cnt == LEN_W'(MAX_LEN)) begin
                    r_sweep_busy <= 1'b0;
                end else begin
                    r_sweep_cnt <= r_sweep_cnt + LEN_W'(1);
                end
            end

            if (in_acc) begin
                case (in_kind)
                    KIND_PAT: ;
                    KIND_LEN: begin
                        r_len[i_in.sig_index] <= len_sat;
                        r_ofs[i_in.sig_index] <= i_in.addr_offset;
                        r_sweep_busy          <= 1'b1;
                        r_sweep_cnt           <= '0;
                        r_sweep_sig           <= i_in.sig_index;
                    end
                    KIND_SCAN: begin
                        if (i_in.last) begin
                            r_found    <= '0;
                            r_count    <= '0;
                            r_complete <= 1'b0;
                        end else if (!r_complete) begin
                            r_found    <= n_found;
                            r_count    <= n_count;
                            r_complete <= n_complete;
                        end
                    end
                    KIND_CLEAR: begin
                        r_found    <= '0;
                        r_count    <= '0;
                        r_complete <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    mmps_result u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_load),
        .i_len   (r_len),
        .i_ofs   (r_ofs),
        .o_busy  (res_busy),
        .o_out   (o_out)
    );

    `MMPS_ASSERT_HOLD(a_sweep_blocks_input, r_sweep_busy, !i_in.ready)
    `MMPS_ASSERT_HOLD(a_pending_blocks_input, res_busy, !i_in.ready)
    `MMPS_ASSERT_NEXT(a_length_starts_sweep, in_acc && (in_kind == KIND_LEN), r_sweep_busy)
    `MMPS_ASSERT_NEXT(a_last_clears_scan, in_acc && (in_kind == KIND_SCAN) && i_in.last, (r_found == '0) && !r_complete && (r_count == '0))

endmodule

/* rtl/core/mmps_cell.sv */
// One window cell: a history byte and the aligned pattern entries of every signature.
`timescale 1ns / 1ps
module mmps_cell import mmps_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  t_cell_wr            i_wr,
    input  logic [BYTE_W-1:0]   i_byte,
    output logic [BYTE_W-1:0]   o_byte,
    output logic [NUM_SIGS-1:0] o_hit
);

    logic [BYTE_W-1:0] r_byte;
    logic              r_wild  [NUM_SIGS];
    logic [BYTE_W-1:0] r_value [NUM_SIGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_ctl.clear) begin
            r_byte <= '0;
        end else if (i_ctl.shift) begin
            r_byte <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SIGS; s++) begin
                r_wild[s] <= 1'b1;
            end
        end else if (i_wr.en) begin
            r_wild[i_wr.sig] <= i_wr.entry.wild;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_value[i_wr.sig] <= i_wr.entry.value;
        end
    end

    always_comb begin
        for (int s = 0; s < NUM_SIGS; s++) begin
            o_hit[s] = r_wild[s] | (r_value[s] == i_byte);
        end
    end

    assign o_byte = r_byte;

endmodule

/* rtl/core/mmps_result.sv */
// Result sequencer: turns a found mask and a status flag into result items.
`timescale 1ns / 1ps
module mmps_result import mmps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_res_load        i_load,
    input  logic [LEN_W-1:0] i_len [NUM_SIGS],
    input  logic [OFS_W-1:0] i_ofs [NUM_SIGS],
    output logic             o_busy,
    mmps_out_if.source       o_out
);

    logic [NUM_SIGS-1:0] r_mask;
    logic                r_status;
    logic                r_all;
    logic [ADDR_W-1:0]   r_base_cnt;

    logic                r_valid;
    logic [SIG_W-1:0]    r_idx;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_is_status;
    logic                r_all_found;
    logic                r_last;

    logic                advance;
    logic                have;
    logic [SIG_W-1:0]    sel;
    logic [NUM_SIGS-1:0] mask_rem;
    logic [LEN_W-1:0]    len_adj;
    logic [ADDR_W-1:0]   match_addr;

    assign have    = (r_mask != '0) || r_status;
    assign advance = !r_valid || o_out.ready;
    assign o_busy  = have;

    always_comb begin
        sel = '0;
        for (int s = NUM_SIGS - 1; s >= 0; s--) begin
            if (r_mask[s]) begin
                sel = SIG_W'(s);
            end
        end
    end

    assign mask_rem   = r_mask & (r_mask - NUM_SIGS'(1));
    assign len_adj    = (i_len[sel] == '0) ? LEN_W'(1) : i_len[sel];
    assign match_addr = r_base_cnt + ADDR_W'(i_ofs[sel]) - ADDR_W'(len_adj);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_status <= 1'b0;
            r_valid  <= 1'b0;
        end else if (i_load.load) begin
            r_mask   <= i_load.mask;
            r_status <= i_load.status;
            if (advance) begin
                r_valid <= 1'b0;
            end
        end else if (advance) begin
            if (r_mask != '0) begin
                r_mask  <= mask_rem;
                r_valid <= 1'b1;
            end else if (r_status) begin
                r_status <= 1'b0;
                r_valid  <= 1'b1;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_all      <= i_load.all_found;
            r_base_cnt <= i_load.base_cnt;
        end
        if (advance && !i_load.load) begin
            if (r_mask != '0) begin
                r_idx       <= sel;
                r_addr      <= match_addr;
                r_is_status <= 1'b0;
                r_all_found <= 1'b0;
                r_last      <= (mask_rem == '0) && !r_status;
            end else begin
                r_idx       <= '0;
                r_addr      <= '0;
                r_is_status <= 1'b1;
                r_all_found <= r_all;
                r_last      <= 1'b1;
            end
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.found_index   = r_idx;
    assign o_out.found_address = r_addr;
    assign o_out.is_status     = r_is_status;
    assign o_out.all_found     = r_all_found;
    assign o_out.last_of_run   = r_last;

endmodule
